### sv/bwe_pkg.sv
// Shared types, character constants and the digit alphabet of the base-24 word encoder.
package bwe_pkg;

    typedef struct packed {
        logic       req_type;
        logic [7:0] data_byte;
    } t_req;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last;
        logic       output_done;
    } t_res;

    localparam logic REQ_DATA = 1'b0;
    localparam logic REQ_END  = 1'b1;

    localparam logic [7:0] CHAR_SLASH   = 8'h2F;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_PAD     = 8'h62;   // alphabet entry zero

    localparam logic [2:0] DIGITS_PER_WORD = 3'd7;
    localparam logic [5:0] COUNT_MAX       = 6'd63;
    localparam logic [5:0] SLASH_COUNT     = 6'd2;

    function automatic logic [7:0] alpha24(input logic [4:0] idx);
        logic [7:0] ch;
        case (idx)
            5'd0:    ch = 8'h62;  // b
            5'd1:    ch = 8'h63;  // c
            5'd2:    ch = 8'h64;  // d
            5'd3:    ch = 8'h66;  // f
            5'd4:    ch = 8'h67;  // g
            5'd5:    ch = 8'h68;  // h
            5'd6:    ch = 8'h6A;  // j
            5'd7:    ch = 8'h6B;  // k
            5'd8:    ch = 8'h6D;  // m
            5'd9:    ch = 8'h6E;  // n
            5'd10:   ch = 8'h70;  // p
            5'd11:   ch = 8'h71;  // q
            5'd12:   ch = 8'h72;  // r
            5'd13:   ch = 8'h73;  // s
            5'd14:   ch = 8'h74;  // t
            5'd15:   ch = 8'h76;  // v
            5'd16:   ch = 8'h77;  // w
            5'd17:   ch = 8'h78;  // x
            5'd18:   ch = 8'h7A;  // z
            5'd19:   ch = 8'h32;  // 2
            5'd20:   ch = 8'h35;  // 5
            5'd21:   ch = 8'h36;  // 6
            5'd22:   ch = 8'h37;  // 7
            5'd23:   ch = 8'h38;  // 8
            default: ch = 8'h62;
        endcase
        return ch;
    endfunction

endpackage

### sv/base24_word_encoder_unit.sv
// Top level of the base-24 word encoder: byte packing, digit sequencer and output register.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------------
//  req     | in        | i_req_valid / o_req_ready  | i_req  (req_type, data_byte)
//  res     | out       | o_res_valid / i_res_ready  | o_res  (out_char, last, output_done)
//  cfg     | in        | i_cfg_we, no wait          | i_cfg_wdata (path_mode)
//
// A byte that does not complete a word is absorbed from the input register.
// A completed word or an end request loads the digit sequencer, which sends one character
// per cycle unless the output stalls (7 digits, plus slash, pads and newline: up to 12); the
// next word loads in the cycle its predecessor's last character enters the output register.
// The output port, one character per cycle unless it stalls, sets the sustained byte rate.
// Reset is synchronous; either side may stall at any time without loss.
module base24_word_encoder_unit #(
    parameter int PATH_LIMIT = 40
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_wdata,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  bwe_pkg::t_req i_req,
    output logic          o_res_valid,
    input  logic          i_res_ready,
    output bwe_pkg::t_res o_res
);

    localparam logic [5:0] LIMIT = 6'(PATH_LIMIT);

    // config and input register
    logic          r_path_mode;
    logic          r_in_valid;
    bwe_pkg::t_req r_in;

    // byte packing
    logic [23:0] r_acc,  n_acc;
    logic [1:0]  r_held, n_held;

    // digit sequencer
    logic [31:0] r_word,  n_word;
    logic [2:0]  r_left,  n_left;
    logic [1:0]  r_pads,  n_pads;
    logic        r_slash, n_slash;
    logic        r_nl,    n_nl;
    logic [5:0]  r_cnt,   n_cnt;
    logic        r_stopped, n_stopped;

    // output register
    logic          r_res_valid;
    bwe_pkg::t_res r_res, n_res;

    logic        step, busy, emit, drained, is_job, consume;
    logic        chk_fire;
    logic [5:0]  chk_cnt, cnt_inc;
    logic [60:0] prod;
    logic [27:0] quot;
    logic [31:0] qx24, rem32;

    // word / 24: shift out the factor 8, divide by 3 through the reciprocal
    assign prod  = 61'(r_word[31:3]) * 61'(32'hAAAA_AAAB);
    assign quot  = prod[60:33];
    assign qx24  = {quot, 4'b0} + {1'b0, quot, 3'b0};
    assign rem32 = r_word - qx24;

    assign cnt_inc = (r_cnt == bwe_pkg::COUNT_MAX) ? r_cnt : r_cnt + 6'd1;

    assign busy = r_slash || (r_left != 3'd0) || (r_pads != 2'd0) || r_nl;
    assign step = !r_res_valid || i_res_ready;
    assign emit = step && busy;

    always_comb begin
        n_word    = r_word;
        n_left    = r_left;
        n_pads    = r_pads;
        n_slash   = r_slash;
        n_nl      = r_nl;
        n_cnt     = r_cnt;
        n_stopped = r_stopped;
        n_res     = r_res;
        chk_cnt   = r_cnt;
        chk_fire  = 1'b0;

        if (emit) begin
            n_res.output_done = 1'b0;
            if (r_slash) begin
                n_res.out_char = bwe_pkg::CHAR_SLASH;
                n_slash        = 1'b0;
            end else if (r_left != 3'd0) begin
                n_res.out_char = bwe_pkg::alpha24(rem32[4:0]);
                n_word         = {4'b0, quot};
                n_left         = r_left - 3'd1;
                n_cnt          = cnt_inc;
                chk_cnt        = cnt_inc;
                chk_fire       = 1'b1;
            end else if (r_pads != 2'd0) begin
                n_res.out_char = bwe_pkg::CHAR_PAD;
                n_pads         = r_pads - 2'd1;
                chk_fire       = 1'b1;
            end else begin
                n_res.out_char    = bwe_pkg::CHAR_NEWLINE;
                n_res.output_done = 1'b1;
                n_nl              = 1'b0;
                n_stopped         = 1'b1;
            end

            // path checks after a digit or pad
            if (chk_fire && r_path_mode) begin
                if (chk_cnt == bwe_pkg::SLASH_COUNT) begin
                    n_slash = 1'b1;
                end else if (chk_cnt >= LIMIT) begin
                    n_left = 3'd0;
                    n_pads = 2'd0;
                    n_nl   = 1'b1;
                end
            end

            n_res.last = !(n_slash || (n_left != 3'd0) || (n_pads != 2'd0) || n_nl);
        end

        drained = !busy || (emit && n_res.last);
        is_job  = (r_in.req_type == bwe_pkg::REQ_END) || (r_held == 2'd3);
        consume = r_in_valid && (!is_job || drained);

        n_acc  = r_acc;
        n_held = r_held;
        if (consume) begin
            if (!is_job) begin
                case (r_held)
                    2'd0:    n_acc[7:0]   = r_in.data_byte;
                    2'd1:    n_acc[15:8]  = r_in.data_byte;
                    default: n_acc[23:16] = r_in.data_byte;
                endcase
                n_held = r_held + 2'd1;
            end else begin
                n_acc  = '0;
                n_held = 2'd0;
                // everything after the closing newline is dropped
                if (!n_stopped) begin
                    n_slash = 1'b0;
                    if (r_in.req_type == bwe_pkg::REQ_DATA) begin
                        n_word = {r_in.data_byte, r_acc};
                        n_left = bwe_pkg::DIGITS_PER_WORD;
                        n_pads = 2'd0;
                        n_nl   = 1'b0;
                    end else begin
                        n_word = {8'b0, r_acc};
                        n_left = (r_held != 2'd0) ? bwe_pkg::DIGITS_PER_WORD : 3'd0;
                        n_pads = (r_held != 2'd0) ? 2'd0 - r_held : 2'd0;
                        n_nl   = 1'b1;
                    end
                end
            end
        end
    end

    assign o_req_ready = !r_in_valid || consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_path_mode <= 1'b0;
            r_in_valid  <= 1'b0;
            r_acc       <= '0;
            r_held      <= '0;
            r_left      <= '0;
            r_pads      <= '0;
            r_slash     <= 1'b0;
            r_nl        <= 1'b0;
            r_cnt       <= '0;
            r_stopped   <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_path_mode <= i_cfg_wdata;
            end
            if (o_req_ready) begin
                r_in_valid <= i_req_valid;
            end
            r_acc     <= n_acc;
            r_held    <= n_held;
            r_left    <= n_left;
            r_pads    <= n_pads;
            r_slash   <= n_slash;
            r_nl      <= n_nl;
            r_cnt     <= n_cnt;
            r_stopped <= n_stopped;
            if (step) begin
                r_res_valid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_req_ready && i_req_valid) begin
            r_in <= i_req;
        end
        r_word <= n_word;
        r_res  <= n_res;
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

### sv/bwe_chk.sv
// Port-level checker for the base-24 word encoder, bound to the top level.
module bwe_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_res_valid,
    input logic          i_res_ready,
    input bwe_pkg::t_res o_res
);

    logic r_done_seen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done_seen <= 1'b0;
        end else if (o_res_valid && i_res_ready && o_res.output_done) begin
            r_done_seen <= 1'b1;
        end
    end

    // nothing follows the closing newline
    a_quiet_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done_seen |-> !o_res_valid)
        else $error("result after closing newline");

    a_done_is_newline: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.output_done |->
            o_res.last && (o_res.out_char == bwe_pkg::CHAR_NEWLINE))
        else $error("closing mark not on a final newline");

    // a slash is always followed by more digits of the same request
    a_slash_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && (o_res.out_char == bwe_pkg::CHAR_SLASH) |-> !o_res.last)
        else $error("slash ends a request");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> o_res_valid && $stable(o_res))
        else $error("stalled result changed");

endmodule

bind base24_word_encoder_unit bwe_chk u_bwe_chk (.*);

### tb/base24_word_encoder_unit_tb.sv
// Self-checking testbench for the base-24 word encoder: random handshakes and a scoreboard.
module base24_word_encoder_unit_tb;

    localparam int PATH_LIMIT    = 40;
    localparam int CLK_PERIOD    = 20;
    localparam int SETTLE_CYCLES = 24;
    localparam int LIMIT_CYCLES  = 400000;
    localparam int IDLE_PCT      = 38;

    // Predicts the character stream and holds the characters still due.
    class char_scoreboard;
        localparam logic [191:0] ALPHABET = "bcdfghjkmnpqrstvwxz25678";

        bit            path_mode;
        logic [23:0]   acc;
        logic [1:0]    held;
        logic [5:0]    count;
        bit            stopped;
        bwe_pkg::t_res due[$];
        bwe_pkg::t_res step_out[$];
        int            errors;

        function new();
            path_mode = 1'b0;
            acc       = '0;
            held      = '0;
            count     = '0;
            stopped   = 1'b0;
            errors    = 0;
        endfunction

        task report(input string msg);
            errors++;
            $display("tb: mismatch: %s", msg);
        endtask

        function logic [7:0] digit_char(input int idx);
            return ALPHABET[8*(23-idx) +: 8];
        endfunction

        function void emit(input logic [7:0] ch, input logic done);
            bwe_pkg::t_res r;
            r.out_char    = ch;
            r.last        = 1'b0;
            r.output_done = done;
            step_out.push_back(r);
        endfunction

        // slash after the second digit, newline once the digit limit is hit
        function bit path_check();
            if (path_mode && count == bwe_pkg::SLASH_COUNT) begin
                emit(bwe_pkg::CHAR_SLASH, 1'b0);
            end else if (path_mode && count >= PATH_LIMIT) begin
                emit(bwe_pkg::CHAR_NEWLINE, 1'b1);
                stopped = 1'b1;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function bit encode(input logic [31:0] w, input int pads);
            logic [31:0] v;
            v = w;
            for (int i = 0; i < 7; i++) begin
                emit(digit_char(int'(v % 24)), 1'b0);
                v = v / 24;
                if (count != bwe_pkg::COUNT_MAX) count = count + 1'b1;
                if (path_check()) return 1'b1;
            end
            for (int i = 0; i < pads; i++) begin
                emit(bwe_pkg::CHAR_PAD, 1'b0);
                if (path_check()) return 1'b1;
            end
            return 1'b0;
        endfunction

        task note_request(input bwe_pkg::t_req r);
            bit            ended;
            bwe_pkg::t_res tail;
            if (stopped) return;
            step_out.delete();
            ended = 1'b0;
            if (r.req_type == bwe_pkg::REQ_DATA) begin
                if (held != 2'd3) begin
                    acc  = acc | 24'({16'd0, r.data_byte} << (8 * held));
                    held = held + 1'b1;
                end else begin
                    ended = encode({r.data_byte, acc}, 0);
                    acc   = '0;
                    held  = '0;
                end
            end else begin
                if (held != 2'd0) begin
                    ended = encode({8'd0, acc}, 4 - int'(held));
                    acc   = '0;
                    held  = '0;
                end
                if (!ended) begin
                    emit(bwe_pkg::CHAR_NEWLINE, 1'b1);
                    stopped = 1'b1;
                end
            end
            if (step_out.size() > 0) begin
                tail      = step_out.pop_back();
                tail.last = 1'b1;
                step_out.push_back(tail);
            end
            foreach (step_out[i]) due.push_back(step_out[i]);
        endtask

        task check_result(input bwe_pkg::t_res got);
            bwe_pkg::t_res want;
            if (due.size() == 0) begin
                report($sformatf("unexpected char %h", got.out_char));
                return;
            end
            want = due.pop_front();
            if (got.out_char !== want.out_char)
                report($sformatf("out_char %h, want %h", got.out_char, want.out_char));
            if (got.last !== want.last)
                report($sformatf("last %b, want %b (char %h)", got.last, want.last,
                                 want.out_char));
            if (got.output_done !== want.output_done)
                report($sformatf("output_done %b, want %b (char %h)", got.output_done,
                                 want.output_done, want.out_char));
        endtask
    endclass

    logic          i_clk;
    logic          i_rst_n;
    logic          i_cfg_we;
    logic          i_cfg_wdata;
    logic          i_req_valid;
    logic          o_req_ready;
    bwe_pkg::t_req i_req;
    logic          o_res_valid;
    logic          i_res_ready;
    bwe_pkg::t_res o_res;

    bit             calm;
    char_scoreboard sb = new();

    base24_word_encoder_unit #(
        .PATH_LIMIT(PATH_LIMIT)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_res       (o_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("tb: failure");
        $finish;
    end

    function automatic bwe_pkg::t_req make_req(input logic kind, input logic [7:0] b);
        bwe_pkg::t_req r;
        r.req_type  = kind;
        r.data_byte = b;
        return r;
    endfunction

    function automatic logic [7:0] pick_byte();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return 8'h00;
        if (sel == 1) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // Valid stays up between back-to-back requests; only idling lowers it.
    task send_request(input bwe_pkg::t_req r);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            i_req_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req       <= r;
        do @(posedge i_clk); while (!o_req_ready);
        sb.note_request(r);
    endtask

    task drain();
        while (sb.due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task write_mode(input logic m);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        sb.path_mode = m;
    endtask

    // result side: random backpressure, check on every accepted character
    initial begin
        i_res_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_res_valid && i_res_ready) sb.check_result(o_res);
            i_res_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    initial begin
        logic [7:0] dir_bytes[18];
        int         n_rand;
        int         ending;

        dir_bytes = '{8'h00, 8'h00, 8'h00, 8'h00,
                      8'hFF, 8'hFF, 8'hFF, 8'hFF,
                      8'h01, 8'h80, 8'h7F, 8'h10,
                      8'h17, 8'h00, 8'h00, 8'h00,
                      8'hAA, 8'h55};
        calm        = 1'b0;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= 1'b0;
        i_req_valid <= 1'b0;
        i_req       <= make_req(bwe_pkg::REQ_DATA, 8'h00);
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // path mode: zero word, all-ones word, mixed words, two bytes left pending
        write_mode(1'b1);
        foreach (dir_bytes[i]) send_request(make_req(bwe_pkg::REQ_DATA, dir_bytes[i]));
        i_req_valid <= 1'b0;
        drain();

        // plain mode with pending bytes carried over; digit count saturates
        write_mode(1'b0);
        n_rand = $urandom_range(90, 110);
        for (int i = 0; i < n_rand; i++) begin
            calm = (i >= 40 && i < 75);
            send_request(make_req(bwe_pkg::REQ_DATA, pick_byte()));
        end
        calm = 1'b0;
        i_req_valid <= 1'b0;
        drain();

        // single stream per reset, so the way it ends is picked at random
        ending = $urandom_range(0, 2);
        if (ending == 0) begin
            write_mode(1'b1);
            while (!sb.stopped) send_request(make_req(bwe_pkg::REQ_DATA, pick_byte()));
        end else if (ending == 1) begin
            send_request(make_req(bwe_pkg::REQ_END, 8'($urandom_range(0, 255))));
        end else begin
            write_mode(1'b1);
            send_request(make_req(bwe_pkg::REQ_END, 8'($urandom_range(0, 255))));
        end

        // after the closing newline everything is dropped
        repeat (12)
            send_request(make_req(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255))));
        i_req_valid <= 1'b0;
        drain();

        if (sb.due.size() != 0)
            sb.report($sformatf("%0d chars never arrived", sb.due.size()));
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
